@@ rtl/core/stc_pkg.sv @@
package stc_pkg;

  // Default sizes
  localparam int MAX_ROW_LENGTH = 1024;
  localparam int ELEV_WIDTH     = 32;

  // Fixed field widths
  localparam int ROW_W          = 16;
  localparam int ROW_LENGTH_W   = 11;
  localparam int SCALE_W        = 32;
  localparam int OUT_COL_W      = 10;
  localparam int CLASS_W        = 8;

  // Register port
  localparam int PADDR_W        = 4;
  localparam int PDATA_W        = 32;

  localparam logic [ROW_W-1:0]        ROW_COUNT_RST   = 16'd1;
  localparam logic [ROW_LENGTH_W-1:0] ROW_LENGTH_RST  = 11'd1;
  localparam logic [SCALE_W-1:0]      SCALE_RST       = 32'd65536;

  // Slope thresholds: tan(15, 30, 45, 60, 75 deg) as unsigned Q2.24
  localparam int NUM_THR        = 5;
  localparam int THR_W          = 26;
  localparam int PROD_W         = THR_W + SCALE_W;
  localparam int SLOPE_SAT_BIT  = 35;
  localparam int FRAC_SHIFT     = 24;
  localparam int CMP_W          = SLOPE_SAT_BIT + FRAC_SHIFT;
  localparam int CLS_W          = 3;

  localparam logic [THR_W-1:0] TAN_THR [NUM_THR] = '{
    26'd4495441, 26'd9686330, 26'd16777216, 26'd29058991, 26'd62613423
  };

  localparam logic [CLASS_W-1:0] CLASS_BORDER  = 8'd255;
  localparam logic [CLASS_W-1:0] CLASS_UNKNOWN = 8'd6;

  // Neighbour slots of the stencil
  localparam int NUM_NB   = 4;
  localparam int NB_UP    = 0;  // row r-2, outer axis
  localparam int NB_DOWN  = 1;  // row r,   outer axis
  localparam int NB_LEFT  = 2;  // col c-1, inner axis
  localparam int NB_RIGHT = 3;  // col c+1, inner axis

  typedef struct packed {
    logic                 a_en;
    logic                 a_border;
    logic                 a_unknown;
    logic                 b_en;
    logic                 b_done;
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
  } meta_t;

  typedef struct packed {
    logic [CLASS_W-1:0]   trav_class;
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
    logic                 done;
  } res_t;

  typedef struct packed {
    logic a_en;
    res_t a;
    logic b_en;
    res_t b;
  } pair_t;

endpackage

@@ rtl/core/stc_cell_if.sv @@
interface stc_cell_if #(
  parameter int ELEV_WIDTH = stc_pkg::ELEV_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic signed [ELEV_WIDTH-1:0] cell_min;
  logic signed [ELEV_WIDTH-1:0] cell_max;
  logic                         has_points;

  modport source (output valid, cell_min, cell_max, has_points, input ready);
  modport sink (input valid, cell_min, cell_max, has_points, output ready);
endinterface

@@ rtl/core/stc_class_if.sv @@
interface stc_class_if;
  logic                             valid;
  logic                             ready;
  logic [stc_pkg::CLASS_W-1:0]      trav_class;
  logic [stc_pkg::ROW_W-1:0]        out_row;
  logic [stc_pkg::OUT_COL_W-1:0]    out_col;
  logic                             grid_done;

  modport source (output valid, trav_class, out_row, out_col, grid_done, input ready);
  modport sink (input valid, trav_class, out_row, out_col, grid_done, output ready);
endinterface

@@ rtl/core/stc_line_mem.sv @@
module stc_line_mem #(
  parameter int DEPTH = stc_pkg::MAX_ROW_LENGTH,
  parameter int WIDTH = 4 * stc_pkg::ELEV_WIDTH + 2
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds between read strobes
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/stc_slope_pipe.sv @@
module stc_slope_pipe #(
  parameter int ELEV_WIDTH = stc_pkg::ELEV_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         in_valid,
  input  logic signed [ELEV_WIDTH-1:0] ctr_min,
  input  logic signed [ELEV_WIDTH-1:0] ctr_max,
  input  logic signed [ELEV_WIDTH-1:0] nb_min [stc_pkg::NUM_NB],
  input  logic signed [ELEV_WIDTH-1:0] nb_max [stc_pkg::NUM_NB],
  input  stc_pkg::meta_t               in_meta,
  input  logic [stc_pkg::SCALE_W-1:0]  scale_outer,
  input  logic [stc_pkg::SCALE_W-1:0]  scale_inner,
  output logic                         out_valid,
  output stc_pkg::pair_t               out_pair
);

  localparam int DX_W = (ELEV_WIDTH > stc_pkg::SLOPE_SAT_BIT) ?
                        ELEV_WIDTH : stc_pkg::SLOPE_SAT_BIT + 1;

  function automatic logic [ELEV_WIDTH-1:0] absdiff(
    input logic signed [ELEV_WIDTH-1:0] a,
    input logic signed [ELEV_WIDTH-1:0] b
  );
    logic signed [ELEV_WIDTH:0] ax;
    logic signed [ELEV_WIDTH:0] bx;
    logic signed [ELEV_WIDTH:0] d;
    ax = {a[ELEV_WIDTH-1], a};
    bx = {b[ELEV_WIDTH-1], b};
    d  = (a >= b) ? (ax - bx) : (bx - ax);
    return d[ELEV_WIDTH-1:0];
  endfunction

  // threshold * scale products, refreshed every cycle from the scale registers
  logic [stc_pkg::SCALE_W-1:0] so_eff, si_eff;
  logic [stc_pkg::PROD_W-1:0]  thr_out [stc_pkg::NUM_THR];
  logic [stc_pkg::PROD_W-1:0]  thr_in  [stc_pkg::NUM_THR];

  assign so_eff = (scale_outer == '0) ? stc_pkg::SCALE_W'(1) : scale_outer;
  assign si_eff = (scale_inner == '0) ? stc_pkg::SCALE_W'(1) : scale_inner;

  always_ff @(posedge clk) begin
    for (int k = 0; k < stc_pkg::NUM_THR; k++) begin
      thr_out[k] <= stc_pkg::PROD_W'(stc_pkg::TAN_THR[k]) * stc_pkg::PROD_W'(so_eff);
      thr_in[k]  <= stc_pkg::PROD_W'(stc_pkg::TAN_THR[k]) * stc_pkg::PROD_W'(si_eff);
    end
  end

  // S1: absolute differences, S2: larger of each pair, S3: threshold counts
  logic                            s1_v, s2_v, s3_v;
  stc_pkg::meta_t                  s1_meta, s2_meta, s3_meta;
  logic [ELEV_WIDTH-1:0]           s1_dlo [stc_pkg::NUM_NB];
  logic [ELEV_WIDTH-1:0]           s1_dhi [stc_pkg::NUM_NB];
  logic [ELEV_WIDTH-1:0]           s2_d   [stc_pkg::NUM_NB];
  logic [stc_pkg::CLS_W-1:0]       s3_cnt [stc_pkg::NUM_NB];
  logic [stc_pkg::CLS_W-1:0]       cnt_next [stc_pkg::NUM_NB];
  logic [stc_pkg::CLS_W-1:0]       best;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else if (adv) begin
      s1_v <= in_valid;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_meta <= in_meta;
      s2_meta <= s1_meta;
      s3_meta <= s2_meta;
      for (int n = 0; n < stc_pkg::NUM_NB; n++) begin
        s1_dlo[n] <= absdiff(ctr_min, nb_max[n]);
        s1_dhi[n] <= absdiff(ctr_max, nb_min[n]);
        s2_d[n]   <= (s1_dlo[n] > s1_dhi[n]) ? s1_dlo[n] : s1_dhi[n];
        s3_cnt[n] <= cnt_next[n];
      end
    end
  end

  // slope >= tan(theta_k)  <=>  d * 2^24 >= T_k * scale; huge d meets all
  always_comb begin
    logic [DX_W-1:0]                dx;
    logic [stc_pkg::CMP_W-1:0]      lhs;
    logic [stc_pkg::PROD_W-1:0]     thr;
    logic                           big;
    logic [stc_pkg::CLS_W-1:0]      cnt;
    for (int n = 0; n < stc_pkg::NUM_NB; n++) begin
      dx  = DX_W'(s2_d[n]);
      lhs = {dx[stc_pkg::SLOPE_SAT_BIT-1:0], {stc_pkg::FRAC_SHIFT{1'b0}}};
      big = |dx[DX_W-1:stc_pkg::SLOPE_SAT_BIT];
      cnt = '0;
      for (int k = 0; k < stc_pkg::NUM_THR; k++) begin
        thr = (n == stc_pkg::NB_UP || n == stc_pkg::NB_DOWN) ? thr_out[k] : thr_in[k];
        if (big || lhs >= stc_pkg::CMP_W'(thr)) begin
          cnt = cnt + stc_pkg::CLS_W'(1);
        end
      end
      cnt_next[n] = cnt;
    end
  end

  always_comb begin
    best = '0;
    for (int n = 0; n < stc_pkg::NUM_NB; n++) begin
      if (s3_cnt[n] > best) begin
        best = s3_cnt[n];
      end
    end
  end

  always_comb begin
    out_valid         = s3_v;
    out_pair.a_en     = s3_meta.a_en;
    if (s3_meta.a_border) begin
      out_pair.a.trav_class = stc_pkg::CLASS_BORDER;
    end else if (s3_meta.a_unknown) begin
      out_pair.a.trav_class = stc_pkg::CLASS_UNKNOWN;
    end else begin
      out_pair.a.trav_class = stc_pkg::CLASS_W'(best);
    end
    out_pair.a.row          = s3_meta.row - stc_pkg::ROW_W'(1);
    out_pair.a.col          = s3_meta.col;
    out_pair.a.done         = 1'b0;
    out_pair.b_en           = s3_meta.b_en;
    out_pair.b.trav_class   = stc_pkg::CLASS_BORDER;
    out_pair.b.row          = s3_meta.row;
    out_pair.b.col          = s3_meta.col;
    out_pair.b.done         = s3_meta.b_done;
  end

endmodule

@@ rtl/core/stc_out_queue.sv @@
module stc_out_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  stc_pkg::pair_t     in_pair,
  output logic               adv,
  stc_class_if.source        classes
);

  stc_pkg::pair_t p;
  logic           p_a, p_b;
  logic           out_load;
  stc_pkg::res_t  pick;

  assign out_load = !classes.valid || classes.ready;
  // pipeline moves when the pair stage empties this cycle
  assign adv  = !(p_a || p_b) || ((p_a ^ p_b) && out_load);
  assign pick = p_a ? p.a : p.b;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_a           <= 1'b0;
      p_b           <= 1'b0;
      classes.valid <= 1'b0;
    end else begin
      if (adv) begin
        p_a <= in_valid && in_pair.a_en;
        p_b <= in_valid && in_pair.b_en;
      end else if (out_load) begin
        p_a <= 1'b0;
      end
      if (out_load) begin
        classes.valid <= p_a || p_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p <= in_pair;
    end
    if (out_load && (p_a || p_b)) begin
      classes.trav_class <= pick.trav_class;
      classes.out_row    <= pick.row;
      classes.out_col    <= pick.col;
      classes.grid_done  <= pick.done;
    end
  end

endmodule

@@ rtl/core/slope_traversability_classifier.sv @@
// Path: the class of interior cell (r-1,c) is made from the beat of cell (r,c) in S1, S2, S3,
// then pair stage and output register; border results of first and last rows take that path.
// Throughput: one cell per cycle while the output is taken; on the last row each cell makes two
// results and the single output register holds off the next cell while both wait.
// Reset: counters, registers and pipeline valids clear; the line memory is not cleared and
// needs no clearing pass, so cells are taken as soon as reset is released.
module slope_traversability_classifier #(
  parameter int MAX_ROW_LENGTH = stc_pkg::MAX_ROW_LENGTH,
  parameter int ELEV_WIDTH     = stc_pkg::ELEV_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  stc_cell_if.sink                    cells,
  stc_class_if.source                 classes,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [stc_pkg::PADDR_W-1:0] paddr,
  input  logic [stc_pkg::PDATA_W-1:0] pwdata,
  output logic [stc_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int ADDR_W  = $clog2(MAX_ROW_LENGTH);
  localparam int LEN_W   = $clog2(MAX_ROW_LENGTH + 1);
  localparam int CL_W    = (LEN_W > stc_pkg::ROW_LENGTH_W) ? LEN_W : stc_pkg::ROW_LENGTH_W;
  localparam int SIDE_W  = 2 * ELEV_WIDTH + 1;
  localparam int ENTRY_W = 2 * SIDE_W;

  typedef enum logic [1:0] {
    REG_ROW_COUNT,
    REG_ROW_LENGTH,
    REG_SCALE_OUTER,
    REG_SCALE_INNER
  } reg_idx_t;

  // ---------------------------------------------------------------------------
  // Register port: one word per register, write lands on the access phase
  // ---------------------------------------------------------------------------
  logic [stc_pkg::ROW_W-1:0]        row_count;
  logic [stc_pkg::ROW_LENGTH_W-1:0] row_length;
  logic [stc_pkg::SCALE_W-1:0]      scale_outer;
  logic [stc_pkg::SCALE_W-1:0]      scale_inner;
  reg_idx_t                         reg_sel;
  logic                             reg_wr;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[stc_pkg::PADDR_W-1:2]);
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count   <= stc_pkg::ROW_COUNT_RST;
      row_length  <= stc_pkg::ROW_LENGTH_RST;
      scale_outer <= stc_pkg::SCALE_RST;
      scale_inner <= stc_pkg::SCALE_RST;
    end else if (reg_wr) begin
      case (reg_sel)
        REG_ROW_COUNT:   row_count   <= pwdata[stc_pkg::ROW_W-1:0];
        REG_ROW_LENGTH:  row_length  <= pwdata[stc_pkg::ROW_LENGTH_W-1:0];
        REG_SCALE_OUTER: scale_outer <= pwdata[stc_pkg::SCALE_W-1:0];
        REG_SCALE_INNER: scale_inner <= pwdata[stc_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ROW_COUNT:   prdata = stc_pkg::PDATA_W'(row_count);
      REG_ROW_LENGTH:  prdata = stc_pkg::PDATA_W'(row_length);
      REG_SCALE_OUTER: prdata = stc_pkg::PDATA_W'(scale_outer);
      REG_SCALE_INNER: prdata = stc_pkg::PDATA_W'(scale_inner);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Effective grid size: zero sizes act as one, long rows clip to the memory
  // ---------------------------------------------------------------------------
  logic [LEN_W-1:0]          len_eff;
  logic [CL_W-1:0]           rl_x;
  logic [stc_pkg::ROW_W-1:0] rows_eff;

  assign rl_x     = CL_W'(row_length);
  assign rows_eff = (row_count == '0) ? stc_pkg::ROW_W'(1) : row_count;

  always_comb begin
    if (row_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (rl_x > CL_W'(MAX_ROW_LENGTH)) begin
      len_eff = LEN_W'(MAX_ROW_LENGTH);
    end else begin
      len_eff = LEN_W'(rl_x);
    end
  end

  // ---------------------------------------------------------------------------
  // Grid position. A position left outside the grid by a register write
  // restarts at (0,0) on the next beat.
  // ---------------------------------------------------------------------------
  logic [stc_pkg::ROW_W-1:0] row_q;
  logic [ADDR_W-1:0]         col_q;
  logic                      restart;
  logic [stc_pkg::ROW_W-1:0] r;
  logic [ADDR_W-1:0]         c;
  logic                      last_col, last_row;
  logic                      accept;
  logic                      adv;

  assign restart  = (LEN_W'(col_q) >= len_eff) || (row_q >= rows_eff);
  assign r        = restart ? '0 : row_q;
  assign c        = restart ? '0 : col_q;
  assign last_col = (LEN_W'(c) == len_eff - LEN_W'(1));
  assign last_row = (r == rows_eff - stc_pkg::ROW_W'(1));

  assign cells.ready = adv;
  assign accept      = cells.valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_q <= '0;
      col_q <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : r + stc_pkg::ROW_W'(1);
      end else begin
        col_q <= c + ADDR_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Line memory. Entry c = {row r-1 side, row r-2 side}, side = {min, max, valid}.
  // Each beat writes entry c back with the new cell pushed in and reads ahead
  // entry c+2 (mod row length). So at the beat of column c:
  //   cur      = entry c   (read two beats ago)
  //   mem_rd   = entry c+1 (read last beat, not yet rewritten)
  //   hold     = row r-1 side of entry c-1 (previous cur)
  // Reads always trail or lead writes by at least one entry for rows of three
  // or more cells; shorter rows are all border and their stencil is unused.
  // ---------------------------------------------------------------------------
  logic [ENTRY_W-1:0] cur;
  logic [ENTRY_W-1:0] mem_rd;
  logic [SIDE_W-1:0]  hold_side;
  logic [SIDE_W-1:0]  cur_prev, cur_old, nxt_prev;
  logic [LEN_W:0]     ahead_sum, ahead_wrap;
  logic [ADDR_W-1:0]  rd_addr;

  assign cur_prev = cur[ENTRY_W-1:SIDE_W];
  assign cur_old  = cur[SIDE_W-1:0];
  assign nxt_prev = mem_rd[ENTRY_W-1:SIDE_W];

  assign ahead_sum  = (LEN_W + 1)'(c) + (LEN_W + 1)'(2);
  assign ahead_wrap = (ahead_sum >= (LEN_W + 1)'(len_eff)) ?
                      ahead_sum - (LEN_W + 1)'(len_eff) : ahead_sum;
  assign rd_addr    = ahead_wrap[ADDR_W-1:0];

  stc_line_mem #(
    .DEPTH (MAX_ROW_LENGTH),
    .WIDTH (ENTRY_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (c),
    .wr_data ({cells.cell_min, cells.cell_max, cells.has_points, cur_prev}),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (mem_rd)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      cur       <= mem_rd;
      hold_side <= cur_prev;
    end
  end

  // ---------------------------------------------------------------------------
  // Stencil operands: centre is row r-1 col c
  // ---------------------------------------------------------------------------
  logic signed [ELEV_WIDTH-1:0] nb_min [stc_pkg::NUM_NB];
  logic signed [ELEV_WIDTH-1:0] nb_max [stc_pkg::NUM_NB];
  stc_pkg::meta_t               meta;

  always_comb begin
    nb_min[stc_pkg::NB_UP]    = cur_old[SIDE_W-1:ELEV_WIDTH+1];
    nb_max[stc_pkg::NB_UP]    = cur_old[ELEV_WIDTH:1];
    nb_min[stc_pkg::NB_DOWN]  = cells.cell_min;
    nb_max[stc_pkg::NB_DOWN]  = cells.cell_max;
    nb_min[stc_pkg::NB_LEFT]  = hold_side[SIDE_W-1:ELEV_WIDTH+1];
    nb_max[stc_pkg::NB_LEFT]  = hold_side[ELEV_WIDTH:1];
    nb_min[stc_pkg::NB_RIGHT] = nxt_prev[SIDE_W-1:ELEV_WIDTH+1];
    nb_max[stc_pkg::NB_RIGHT] = nxt_prev[ELEV_WIDTH:1];
  end

  // result a: class of (r-1,c), from row 2 on; result b: own border result
  // on the first and last rows
  always_comb begin
    meta.a_en      = (r >= stc_pkg::ROW_W'(2));
    meta.a_border  = (c == '0) || last_col;
    meta.a_unknown = !cur_prev[0] || !hold_side[0] || !nxt_prev[0] || !cur_old[0] ||
                     !cells.has_points;
    meta.b_en      = (r == '0) || last_row;
    meta.b_done    = last_row && last_col;
    meta.row       = r;
    meta.col       = stc_pkg::OUT_COL_W'(c);
  end

  logic           pipe_v;
  stc_pkg::pair_t pipe_pair;

  stc_slope_pipe #(
    .ELEV_WIDTH (ELEV_WIDTH)
  ) u_pipe (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_valid    (accept),
    .ctr_min     (cur_prev[SIDE_W-1:ELEV_WIDTH+1]),
    .ctr_max     (cur_prev[ELEV_WIDTH:1]),
    .nb_min      (nb_min),
    .nb_max      (nb_max),
    .in_meta     (meta),
    .scale_outer (scale_outer),
    .scale_inner (scale_inner),
    .out_valid   (pipe_v),
    .out_pair    (pipe_pair)
  );

  // pair stage + output register; stalls the whole pipe while two results wait or the output is blocked
  stc_out_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pipe_v),
    .in_pair  (pipe_pair),
    .adv      (adv),
    .classes  (classes)
  );

`ifndef SYNTHESIS
  a_done_border: assert property (@(posedge clk) disable iff (rst)
    classes.valid && classes.grid_done |-> classes.trav_class == stc_pkg::CLASS_BORDER)
    else $error("grid end flagged on a non-border result");

  a_class_range: assert property (@(posedge clk) disable iff (rst)
    classes.valid |-> (classes.trav_class <= stc_pkg::CLASS_UNKNOWN) ||
                      (classes.trav_class == stc_pkg::CLASS_BORDER))
    else $error("class code out of range");

  a_grid_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && last_row && last_col |=> (row_q == '0) && (col_q == '0))
    else $error("position did not wrap after last cell");
`endif

endmodule
